>>> src/b64_pkg.sv
// b64_pkg: shared types, constants and the sextet-to-character function
// for the base64 stream encoder. No dependencies.

package b64_pkg;

    localparam int GROUP_CHARS = 4;
    localparam int IDX_W       = $clog2(GROUP_CHARS);
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // number of real bytes in a group
    localparam logic [1:0] NVALID_ONE   = 2'd1;
    localparam logic [1:0] NVALID_TWO   = 2'd2;
    localparam logic [1:0] NVALID_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nvalid;
        logic       final_group;
    } group_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_flags_t;

    // standard alphabet A-Z a-z 0-9 + /
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = 7'h61 + {1'b0, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            c = 7'h30 + {1'b0, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            c = 7'h2B;
        end
        else
        begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

>>> src/b64_front.sv
// b64_front: accepts raw bytes, holds up to two pending bytes and forms
// complete or final groups for the queue. Depends on b64_pkg.

module b64_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            q_not_full,
    output logic            in_ready,
    output logic            push,
    output b64_pkg::group_t group
);

    logic [7:0] first_reg,  first_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] count_reg,  count_next;
    logic       accept;

    assign in_ready = q_not_full;
    assign accept   = in_valid && q_not_full;

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        push        = 1'b0;
        group       = '0;
        if (count_reg[1])
        begin
            group.b0     = first_reg;
            group.b1     = second_reg;
            group.b2     = in_byte;
            group.nvalid = b64_pkg::NVALID_THREE;
        end
        else if (count_reg == 2'd1)
        begin
            group.b0     = first_reg;
            group.b1     = in_byte;
            group.nvalid = b64_pkg::NVALID_TWO;
        end
        else
        begin
            group.b0     = in_byte;
            group.nvalid = b64_pkg::NVALID_ONE;
        end
        group.final_group = in_last;
        if (accept)
        begin
            if (count_reg[1] || in_last)
            begin
                push        = 1'b1;
                count_next  = 2'd0;
                first_next  = 8'd0;
                second_next = 8'd0;
            end
            else if (count_reg == 2'd1)
            begin
                second_next = in_byte;
                count_next  = 2'd2;
            end
            else
            begin
                first_next = in_byte;
                count_next = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

endmodule

>>> src/b64_queue.sv
// b64_queue: short group queue between front and back ends, head is
// presented registered for the back end to peek. Depends on b64_pkg.

module b64_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64_pkg::group_t    wr_group,
    input  logic               pop,
    output b64_pkg::group_t    head,
    output b64_pkg::q_flags_t  flags
);

    b64_pkg::group_t            entry_reg [b64_pkg::Q_DEPTH];
    logic [b64_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [b64_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [b64_pkg::Q_CW-1:0]   count_reg,  count_next;

    localparam logic [b64_pkg::Q_CW-1:0] FULL_COUNT = b64_pkg::Q_CW'(b64_pkg::Q_DEPTH);
    localparam logic [b64_pkg::Q_AW-1:0] LAST_PTR   = b64_pkg::Q_AW'(b64_pkg::Q_DEPTH - 1);

    assign head            = entry_reg[rd_ptr_reg];
    assign flags.not_empty = (count_reg != '0);
    assign flags.not_full  = (count_reg != FULL_COUNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_group;
        end
    end

endmodule

>>> src/b64_back.sv
// b64_back: walks the queue head into the output register, one character per cycle
// while the output is not stalled, and pops the group as its fourth character is loaded. Depends on b64_pkg.

module b64_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  b64_pkg::group_t   head,
    input  logic              head_valid,
    input  logic              out_ready,
    output logic              pop,
    output logic              out_valid,
    output logic [6:0]        out_char,
    output logic              out_last
);

    logic [b64_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic                      last_reg,  last_next;
    logic [6:0]                char_reg,  char_next;
    logic                      advance;
    logic [5:0]                sextet;
    logic                      use_pad;
    logic                      idx_end;

    localparam logic [b64_pkg::IDX_W-1:0] IDX_LAST = b64_pkg::IDX_W'(b64_pkg::GROUP_CHARS - 1);

    assign advance = !valid_reg || out_ready;
    assign idx_end = (idx_reg == IDX_LAST);

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                sextet  = head.b0[7:2];
                use_pad = 1'b0;
            end
            2'd1:
            begin
                sextet  = {head.b0[1:0], head.b1[7:4]};
                use_pad = 1'b0;
            end
            2'd2:
            begin
                sextet  = {head.b1[3:0], head.b2[7:6]};
                use_pad = (head.nvalid == b64_pkg::NVALID_ONE);
            end
            default:
            begin
                sextet  = head.b2[5:0];
                use_pad = (head.nvalid != b64_pkg::NVALID_THREE);
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        char_next  = char_reg;
        pop        = 1'b0;
        if (advance)
        begin
            if (head_valid)
            begin
                valid_next = 1'b1;
                char_next  = use_pad ? b64_pkg::PAD_CHAR : b64_pkg::sextet_char(sextet);
                last_next  = idx_end && head.final_group;
                idx_next   = idx_reg + 1'b1;
                pop        = idx_end;
            end
            else
            begin
                valid_next = 1'b0;
                last_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

>>> src/base64_stream_encoder.sv
// base64_stream_encoder: top level, front end gathers byte groups, queue,
// back end emits characters. Depends on b64_pkg, b64_front, b64_queue, b64_back.
//
//  channel  dir  handshake                    tdata              tlast
//  s_axis   in   s_axis_tvalid/s_axis_tready  [7:0] in_byte      last_byte
//  m_axis   out  m_axis_tvalid/m_axis_tready  [6:0] out_char     end_of_output
//
// a group of three bytes yields four characters, one per cycle from the
// output register while m_axis_tready holds; a final group of one or two
// bytes also yields four characters, padded with '='. the character
// serializer sets the sustained input rate.
// the two-entry group queue lets bytes keep arriving while output stalls;
// s_axis_tready drops only when the queue is full.
// reset clears pending count, queue pointers and output valid.

module base64_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast
);

    b64_pkg::group_t   push_group;
    b64_pkg::group_t   head;
    b64_pkg::q_flags_t q_flags;
    logic              push;
    logic              pop;
    logic [6:0]        out_char;

    b64_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .q_not_full (q_flags.not_full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .group      (push_group)
    );

    b64_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_group (push_group),
        .pop      (pop),
        .head     (head),
        .flags    (q_flags)
    );

    b64_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_flags.not_empty),
        .out_ready  (m_axis_tready),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_char   (out_char),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

    ast_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_flags.not_full)
        else $error("group pushed into a full queue");

    ast_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_flags.not_empty)
        else $error("group popped from an empty queue");

    ast_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tlast |-> m_axis_tvalid)
        else $error("end of output flagged without a character");

    ast_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("group retired without its last character shown");

endmodule

>>> tb/tb_base64_stream_encoder.sv
// tb_base64_stream_encoder: self-checking testbench for the base64 stream encoder.
// Drives byte transfers with message ends, predicts the character stream
// internally and checks every output transfer. Depends on base64_stream_encoder.

module tb_base64_stream_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_HALF     = 4;
    localparam int         RESET_CYCLES = 12;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         RANDOM_BYTES = 224;
    localparam int         NUM_PHASES   = 4;
    localparam int         NUM_DIRECTED = 21;
    localparam logic [6:0] EQ_SIGN      = 7'h3D;

    // index 0 holds the first character of the literal
    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [6:0] ch;
        logic       fin;
    } b64_char_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [31:0] text;    // four ASCII characters, first in the top byte
    } byte_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [6:0] out_char, [7] zero
    logic       m_axis_tlast;

    // idle and stall percentages of the current phase
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    int mismatches  = 0;
    int chars_taken = 0;

    b64_char_t awaited_chars[$];

    logic [7:0] held_first  = 8'h00;
    logic [7:0] held_second = 8'h00;
    logic [1:0] held_count  = 2'd0;

    byte_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{8'h00, 1'b1, 1'b1, "AA=="},
        '{8'hFF, 1'b1, 1'b1, "/w=="},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b1, "AAA="},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b1, "//8="},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, "AAAA"},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b1, "////"},
        '{8'h4D, 1'b0, 1'b0, 32'h0},
        '{8'h61, 1'b0, 1'b0, 32'h0},
        '{8'h6E, 1'b1, 1'b1, "TWFu"},
        '{8'hFB, 1'b0, 1'b0, 32'h0},
        '{8'hEF, 1'b0, 1'b0, 32'h0},
        '{8'hBE, 1'b0, 1'b0, 32'h0},
        '{8'h12, 1'b1, 1'b0, 32'h0},
        '{8'h80, 1'b0, 1'b0, 32'h0},
        '{8'h01, 1'b1, 1'b0, 32'h0}
    };

    base64_stream_encoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
        return B64_ALPHABET[v][6:0];
    endfunction

    // advances the held bytes; returns 1 when a group of four characters leaves
    function automatic logic encode_step(input logic [7:0] b, input logic is_last,
                                         output logic [27:0] chars);
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [1:0] real_bytes;
        chars = '0;
        if (held_count >= 2'd2)
        begin
            g0 = held_first;
            g1 = held_second;
            g2 = b;
            real_bytes = 2'd3;
        end
        else if (is_last)
        begin
            g0 = (held_count == 2'd1) ? held_first : b;
            g1 = (held_count == 2'd1) ? b : 8'h00;
            g2 = 8'h00;
            real_bytes = (held_count == 2'd1) ? 2'd2 : 2'd1;
        end
        else
        begin
            if (held_count == 2'd1)
                held_second = b;
            else
                held_first = b;
            held_count = held_count + 2'd1;
            return 1'b0;
        end
        held_first  = 8'h00;
        held_second = 8'h00;
        held_count  = 2'd0;
        chars = {sextet_to_ascii(g0[7:2]),
                 sextet_to_ascii({g0[1:0], g1[7:4]}),
                 (real_bytes >= 2'd2) ? sextet_to_ascii({g1[3:0], g2[7:6]}) : EQ_SIGN,
                 (real_bytes == 2'd3) ? sextet_to_ascii(g2[5:0]) : EQ_SIGN};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] char %0d: %s got %02h want %02h", $realtime, chars_taken,
                 what, got, want);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic typed, input logic [31:0] text);
        logic [27:0] chars;
        logic        emits;
        b64_char_t   c;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        emits = encode_step(b, is_last, chars);
        if (typed)
            chars = {text[30:24], text[22:16], text[14:8], text[6:0]};
        if (emits)
        begin
            for (int k = 3; k >= 0; k--)
            begin
                c.ch  = chars[k*7 +: 7];
                c.fin = (k == 0) && is_last;
                awaited_chars.push_back(c);
            end
        end
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1, 1'b0, 32'h0);
    endtask

    // receiver side: one ready decision per falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin : char_check
        b64_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_chars.size() == 0)
            begin
                report_mismatch("transfer with nothing awaited", m_axis_tdata, 8'h00);
            end
            else
            begin
                want = awaited_chars.pop_front();
                if (m_axis_tdata !== {1'b0, want.ch})
                    report_mismatch("out_char", m_axis_tdata, {1'b0, want.ch});
                if (m_axis_tlast !== want.fin)
                    report_mismatch("end_of_output", {7'd0, m_axis_tlast}, {7'd0, want.fin});
            end
            chars_taken++;
        end
    end

    initial
    begin
        #(2_000_000);
        $display("tb_base64_stream_encoder NOT OK");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].text);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 54;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 54;
                end
                default:
                begin
                    src_idle_pct  = 22;
                    snk_stall_pct = 22;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_BYTES / NUM_PHASES)
            begin
                // mostly short messages so every tail length shows up often
                if ($urandom_range(7) == 0)
                    len = $urandom_range(40, 10);
                else
                    len = $urandom_range(9, 1);
                send_message(len);
                sent += len;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_base64_stream_encoder OK");
        else
            $display("tb_base64_stream_encoder NOT OK");
        $finish;
    end

endmodule
